// ===== src/tga_rle_pkg.sv =====
// Shared constants and types of the TGA run-length pixel decoder.
package tga_rle_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAlphaEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPixelCount  = 1'd1;

  // Packet header layout.
  localparam logic [ByteW-1:0] HdrLenMask = 8'h7f;
  localparam logic [ByteW-1:0] HdrRunFlag = 8'h80;

  typedef logic [1:0] byte_slot_t;

  // Position of the next byte within a pixel.
  localparam byte_slot_t SlotBlue  = 2'd0;
  localparam byte_slot_t SlotGreen = 2'd1;
  localparam byte_slot_t SlotRed   = 2'd2;
  localparam byte_slot_t SlotAlpha = 2'd3;

endpackage

// ===== src/tga_rle_pixel_decoder_core.sv =====
// TGA true-color run-length pixel decoder: bytes in, pixels with repeat counts out.
//
// This block takes the compressed pixel stream of a TGA true-color image one
// byte per beat and returns one result beat for each completed pixel. A header
// byte opens a packet of (low 7 bits + 1) pixels, clamped to the pixels still
// missing in the image. A run packet yields one result whose repeat_res_o holds
// the packet length; a raw packet yields one result per literal pixel with a
// repeat of one. Pixels arrive as blue, green, red and, when alpha_enable is
// set, alpha; otherwise alpha_o reads 0. image_done_o marks the result that
// finishes the image, and the byte after it is the header of the next image.
// Every byte is decoded in the cycle it is accepted and its result, if any, is
// visible in the output register in the next cycle; the block takes one byte
// per cycle unless stalled. The single output register is the only buffering:
// a new byte is accepted whenever the output register is empty or is being
// drained in the same cycle. Writing pixel_count (index 1) reloads the pixel
// budget and drops any packet in progress; writing alpha_enable (index 0)
// takes effect at the next red byte. Configuration writes are always taken
// and should only be issued while the block is idle.
module tga_rle_pixel_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Compressed byte stream.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tga_rle_pkg::ByteW-1:0]    data_byte_i,
  // Decoded pixels.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tga_rle_pkg::ByteW-1:0]    blue_o,
  output logic [tga_rle_pkg::ByteW-1:0]    green_o,
  output logic [tga_rle_pkg::ByteW-1:0]    red_o,
  output logic [tga_rle_pkg::ByteW-1:0]    alpha_o,
  output logic [tga_rle_pkg::ByteW-1:0]    repeat_res_o,
  output logic                             image_done_o,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tga_rle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tga_rle_pkg::CountW-1:0]   cfg_data_i
);
  import tga_rle_pkg::*;

  // Configuration.
  logic              alpha_enable_q;
  logic [CountW-1:0] pixel_count_q;   // Already clamped to at least one.

  // Decode state.
  logic [CountW-1:0] pixels_left_q, pixels_left_d;
  logic [ByteW-1:0]  packet_left_q, packet_left_d;
  logic              packet_is_run_q, packet_is_run_d;
  byte_slot_t        byte_slot_q, byte_slot_d;
  logic [ByteW-1:0]  gather_blue_q, gather_blue_d;
  logic [ByteW-1:0]  gather_green_q, gather_green_d;
  logic [ByteW-1:0]  gather_red_q, gather_red_d;

  // Output register.
  logic              out_valid_q;
  logic [ByteW-1:0]  blue_q, green_q, red_q, alpha_q, repeat_q;
  logic              done_q;

  logic              in_fire;
  logic              cfg_fire;
  logic              emit;
  logic [ByteW-1:0]  emit_red;
  logic [ByteW-1:0]  emit_alpha;
  logic [ByteW-1:0]  emit_repeat;
  logic              emit_done;

  // Header decode signals.
  logic [CountW-1:0] budget;
  logic [ByteW-1:0]  hdr_len;
  logic [ByteW-1:0]  pkt_len;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    budget  = (pixels_left_q == '0) ? pixel_count_q : pixels_left_q;
    hdr_len = (data_byte_i & HdrLenMask) + ByteW'(1);
    if (budget < CountW'(hdr_len)) begin
      pkt_len = budget[ByteW-1:0];
    end else begin
      pkt_len = hdr_len;
    end
  end

  always_comb begin
    pixels_left_d   = pixels_left_q;
    packet_left_d   = packet_left_q;
    packet_is_run_d = packet_is_run_q;
    byte_slot_d     = byte_slot_q;
    gather_blue_d   = gather_blue_q;
    gather_green_d  = gather_green_q;
    gather_red_d    = gather_red_q;
    emit            = 1'b0;
    emit_red        = gather_red_q;
    emit_alpha      = '0;
    emit_repeat     = ByteW'(1);
    emit_done       = 1'b0;

    if (packet_left_q == '0) begin
      // Header byte: open a new packet.
      pixels_left_d   = budget - CountW'(pkt_len);
      packet_left_d   = pkt_len;
      packet_is_run_d = (data_byte_i & HdrRunFlag) != '0;
      byte_slot_d     = SlotBlue;
    end else begin
      case (byte_slot_q)
        SlotBlue: begin
          gather_blue_d = data_byte_i;
          byte_slot_d   = SlotGreen;
        end
        SlotGreen: begin
          gather_green_d = data_byte_i;
          byte_slot_d    = SlotRed;
        end
        SlotRed: begin
          gather_red_d = data_byte_i;
          emit_red     = data_byte_i;
          if (alpha_enable_q) begin
            byte_slot_d = SlotAlpha;
          end else begin
            emit = 1'b1;
          end
        end
        SlotAlpha: begin
          emit_alpha = data_byte_i;
          emit       = 1'b1;
        end
        default: begin
          byte_slot_d = SlotBlue;
        end
      endcase

      if (emit) begin
        byte_slot_d = SlotBlue;
        if (packet_is_run_q) begin
          emit_repeat   = packet_left_q;
          packet_left_d = '0;
        end else begin
          packet_left_d = packet_left_q - ByteW'(1);
        end
        emit_done = (packet_left_d == '0) && (pixels_left_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_enable_q  <= 1'b0;
      pixel_count_q   <= CountW'(1);
      pixels_left_q   <= CountW'(1);
      packet_left_q   <= '0;
      packet_is_run_q <= 1'b0;
      byte_slot_q     <= SlotBlue;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index_i == CfgAlphaEnable) begin
          alpha_enable_q <= cfg_data_i[0];
        end else begin
          // Writing the pixel count restarts the image.
          pixel_count_q   <= (cfg_data_i == '0) ? CountW'(1) : cfg_data_i;
          pixels_left_q   <= (cfg_data_i == '0) ? CountW'(1) : cfg_data_i;
          packet_left_q   <= '0;
          packet_is_run_q <= 1'b0;
          byte_slot_q     <= SlotBlue;
        end
      end else if (in_fire) begin
        pixels_left_q   <= pixels_left_d;
        packet_left_q   <= packet_left_d;
        packet_is_run_q <= packet_is_run_d;
        byte_slot_q     <= byte_slot_d;
      end

      if (in_fire) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      gather_blue_q  <= gather_blue_d;
      gather_green_q <= gather_green_d;
      gather_red_q   <= gather_red_d;
      if (emit) begin
        blue_q   <= gather_blue_q;
        green_q  <= gather_green_q;
        red_q    <= emit_red;
        alpha_q  <= emit_alpha;
        repeat_q <= emit_repeat;
        done_q   <= emit_done;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign blue_o       = blue_q;
  assign green_o      = green_q;
  assign red_o        = red_q;
  assign alpha_o      = alpha_q;
  assign repeat_res_o = repeat_q;
  assign image_done_o = done_q;

`ifndef SYNTHESIS
  // A packet never holds more than 128 pixels.
  a_packet_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    packet_left_q <= ByteW'(128))
    else $error("packet_left exceeds 128");

  // Pixel bytes are only gathered inside an open packet.
  a_slot_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_slot_q != SlotBlue) |-> (packet_left_q != '0))
    else $error("pixel byte slot advanced outside a packet");

  // Every delivered pixel has a repeat count between 1 and 128.
  a_repeat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_res_o != '0) && (repeat_res_o <= ByteW'(128)))
    else $error("repeat count out of range");

  // A result that finishes the image leaves no pixels and no packet pending.
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && emit_done && !cfg_fire) |=>
      (packet_left_q == '0) && (pixels_left_q == '0))
    else $error("image done with pixels still pending");
`endif

endmodule
